/* hdl/efp_pkg.sv */
// ----------------------------------------------------------------------------
// efp_pkg
// Shared types and constants of the escape-time fractal pixel block.
// ----------------------------------------------------------------------------
package efp_pkg;

    // Pixel index width
    localparam int PIX_W = 10;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_REAL_START   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_START   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_ENABLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_C_REAL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_C_IMAG = 3'd7;

    // Reset values of the coordinate registers, in Q4.28
    localparam logic signed [63:0] RST_REAL_START_Q28 = -64'sd1426063360;
    localparam logic signed [63:0] RST_REAL_STEP_Q28  = 64'sd8388608;
    localparam logic signed [63:0] RST_IMAG_START_Q28 = 64'sd536870912;
    localparam logic signed [63:0] RST_IMAG_STEP_Q28  = -64'sd10737418;
    localparam int                 RST_ITER_LIMIT     = 10;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_SQUARE,
        ST_EVAL,
        ST_DONE
    } efp_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic map;
        logic square;
        logic eval;
        logic out_load;
    } efp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic limit_zero;
        logic stop_sq;
        logic stop_ev;
    } efp_stat_t;

endpackage

/* hdl/efp_if.sv */
// ----------------------------------------------------------------------------
// efp_if
// Valid/ready channels of the fractal pixel block: pixel in, result out.
// ----------------------------------------------------------------------------
interface efp_pix_if;
    logic                         valid;
    logic                         ready;
    logic [efp_pkg::PIX_W-1:0]    pixel_col;
    logic [efp_pkg::PIX_W-1:0]    pixel_row;

    modport source (output valid, output pixel_col, output pixel_row, input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface efp_res_if #(
    parameter int COUNT_WIDTH = 12
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             color_index;
    logic                   escaped;
    logic [COUNT_WIDTH-1:0] iter_count;

    modport source (output valid, output color_index, output escaped, output iter_count,
                    input ready);
    modport sink   (input valid, input color_index, input escaped, input iter_count,
                    output ready);
endinterface

/* hdl/efp_ctrl.sv */
// ----------------------------------------------------------------------------
// efp_ctrl
// Sequencer of one pixel: map, then square / evaluate per iteration, then hand
// the result to the output register.
// ----------------------------------------------------------------------------
module efp_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  efp_pkg::efp_stat_t  stat,
    output efp_pkg::efp_cmd_t   cmd
);

    efp_pkg::efp_state_t state_reg;
    efp_pkg::efp_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            efp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = efp_pkg::ST_MAP;
                end
            end
            efp_pkg::ST_MAP:
            begin
                state_next = stat.limit_zero ? efp_pkg::ST_DONE : efp_pkg::ST_SQUARE;
            end
            efp_pkg::ST_SQUARE:
            begin
                state_next = stat.stop_sq ? efp_pkg::ST_DONE : efp_pkg::ST_EVAL;
            end
            efp_pkg::ST_EVAL:
            begin
                state_next = stat.stop_ev ? efp_pkg::ST_DONE : efp_pkg::ST_SQUARE;
            end
            efp_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = efp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = efp_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            efp_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            efp_pkg::ST_MAP:
            begin
                cmd.map = 1'b1;
            end
            efp_pkg::ST_SQUARE:
            begin
                cmd.square = 1'b1;
            end
            efp_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            efp_pkg::ST_DONE:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Hold the result valid until taken
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= efp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hdl/efp_dpath.sv */
// ----------------------------------------------------------------------------
// efp_dpath
// Coordinate mapping, complex square-add, escape tests, colour and the
// result register.
// ----------------------------------------------------------------------------
module efp_dpath #(
    parameter int COORD_WIDTH = 32,
    parameter int COUNT_WIDTH = 12
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  efp_pkg::efp_cmd_t               cmd,
    output efp_pkg::efp_stat_t              stat,
    input  logic [efp_pkg::PIX_W-1:0]       pixel_col,
    input  logic [efp_pkg::PIX_W-1:0]       pixel_row,
    input  logic signed [COORD_WIDTH-1:0]   real_start,
    input  logic signed [COORD_WIDTH-1:0]   real_step,
    input  logic signed [COORD_WIDTH-1:0]   imag_start,
    input  logic signed [COORD_WIDTH-1:0]   imag_step,
    input  logic [COUNT_WIDTH-1:0]          iter_limit,
    input  logic                            julia_enable,
    input  logic signed [COORD_WIDTH-1:0]   julia_c_real,
    input  logic signed [COORD_WIDTH-1:0]   julia_c_imag,
    output logic [1:0]                      color_index,
    output logic                            escaped,
    output logic [COUNT_WIDTH-1:0]          iter_count
);

    localparam int W  = COORD_WIDTH;
    localparam int F  = COORD_WIDTH - 4;
    localparam int ZW = COORD_WIDTH + 6;
    localparam int PW = 2 * COORD_WIDTH;
    localparam int MW = COORD_WIDTH + efp_pkg::PIX_W + 1;

    localparam logic signed [ZW-1:0] TWO     = ZW'(1) <<< (F + 1);
    localparam logic signed [ZW-1:0] NEG_TWO = -TWO;
    localparam logic [PW:0]          FOUR_SQ = (PW + 1)'(1) << (2 * F + 2);

    logic [efp_pkg::PIX_W-1:0] col_reg;
    logic [efp_pkg::PIX_W-1:0] row_reg;
    logic signed [ZW-1:0]      zr_reg;
    logic signed [ZW-1:0]      zi_reg;
    logic signed [W-1:0]       cr_reg;
    logic signed [W-1:0]       ci_reg;
    logic signed [PW-1:0]      prr_reg;
    logic signed [PW-1:0]      pii_reg;
    logic signed [PW-1:0]      pri_reg;
    logic [COUNT_WIDTH-1:0]    cnt_reg;
    logic [COUNT_WIDTH-1:0]    cnt_next;
    logic [1:0]                base_reg;
    logic [1:0]                base_next;
    logic                      pending_reg;
    logic                      esc_reg;
    logic [1:0]                color_reg;
    logic                      escaped_reg;
    logic [COUNT_WIDTH-1:0]    iter_reg;

    logic signed [MW-1:0]      col_prod;
    logic signed [MW-1:0]      row_prod;
    logic signed [W-1:0]       pr;
    logic signed [W-1:0]       pi;
    logic signed [W-1:0]       zr_w;
    logic signed [W-1:0]       zi_w;
    logic signed [PW:0]        diff;
    logic signed [PW:0]        diff_sh;
    logic signed [PW-1:0]      cross_sh;
    logic signed [ZW-1:0]      nr;
    logic signed [ZW-1:0]      ni;
    logic [PW:0]               sumsq;
    logic                      big;
    logic                      sum_esc;
    logic                      last;
    logic                      gap;
    logic                      bump;
    logic [2:0]                color_sum;
    logic [1:0]                color_calc;

    // Map pixel indexes to the complex plane, wrapping to the coordinate width
    assign col_prod = $signed({1'b0, col_reg}) * real_step;
    assign row_prod = $signed({1'b0, row_reg}) * imag_step;
    assign pr       = real_start + col_prod[W-1:0];
    assign pi       = imag_start + row_prod[W-1:0];

    // Current z in coordinate format
    assign zr_w = zr_reg[W-1:0];
    assign zi_w = zi_reg[W-1:0];

    // Square-add: floor shifts of the products plus c
    assign diff     = (PW + 1)'(prr_reg) - (PW + 1)'(pii_reg);
    assign diff_sh  = diff >>> F;
    assign cross_sh = pri_reg >>> (F - 1);
    assign nr       = ZW'(diff_sh) + ZW'(cr_reg);
    assign ni       = ZW'(cross_sh) + ZW'(ci_reg);

    // Escape tests
    assign big     = (zr_reg > TWO) || (zr_reg < NEG_TWO) || (zi_reg > TWO) || (zi_reg < NEG_TWO);
    assign sumsq   = {1'b0, prr_reg} + {1'b0, pii_reg};
    assign sum_esc = sumsq > FOUR_SQ;
    assign last    = ({1'b0, cnt_reg} + 1'b1) == {1'b0, iter_limit};

    assign stat.limit_zero = (iter_limit == '0);
    assign stat.stop_sq    = pending_reg && big;
    assign stat.stop_ev    = pending_reg && (sum_esc || last);

    // Advance the iteration count and its colour band modulo three
    always_comb
    begin
        cnt_next  = cnt_reg + 1'b1;
        base_next = base_reg;
        if (cnt_reg[1:0] == 2'b11)
        begin
            base_next = (base_reg == 2'd2) ? 2'd0 : base_reg + 2'd1;
        end
    end

    // Dithered colour of an escape at the current iteration
    assign gap = row_reg[0] && !col_reg[0];

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd1:    bump = gap;
            2'd2:    bump = col_reg[0] ^ row_reg[0];
            2'd3:    bump = !gap;
            default: bump = 1'b0;
        endcase
    end

    assign color_sum  = {1'b0, base_reg} + 3'd1 + {2'b00, bump};
    assign color_calc = (color_sum > 3'd3) ? 2'd1 : color_sum[1:0];

    // Iteration control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            base_reg    <= '0;
            pending_reg <= 1'b0;
            esc_reg     <= 1'b0;
        end
        else if (cmd.map)
        begin
            cnt_reg     <= '0;
            base_reg    <= '0;
            pending_reg <= 1'b0;
            esc_reg     <= 1'b0;
        end
        else if (cmd.square)
        begin
            if (pending_reg && big)
            begin
                esc_reg <= 1'b1;
            end
        end
        else if (cmd.eval)
        begin
            if (pending_reg && sum_esc)
            begin
                esc_reg <= 1'b1;
            end
            else
            begin
                pending_reg <= 1'b1;
                if (pending_reg)
                begin
                    cnt_reg  <= cnt_next;
                    base_reg <= base_next;
                end
            end
        end
    end

    // Pixel, coordinate and product registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            col_reg <= pixel_col;
            row_reg <= pixel_row;
        end
        if (cmd.map)
        begin
            zr_reg <= ZW'(pr);
            zi_reg <= ZW'(pi);
            cr_reg <= julia_enable ? julia_c_real : pr;
            ci_reg <= julia_enable ? julia_c_imag : pi;
        end
        if (cmd.square)
        begin
            prr_reg <= zr_w * zr_w;
            pii_reg <= zi_w * zi_w;
            pri_reg <= zr_w * zi_w;
        end
        if (cmd.eval && !(pending_reg && (sum_esc || last)))
        begin
            zr_reg <= nr;
            zi_reg <= ni;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            color_reg   <= esc_reg ? color_calc : 2'd0;
            escaped_reg <= esc_reg;
            iter_reg    <= cnt_reg;
        end
    end

    assign color_index = color_reg;
    assign escaped     = escaped_reg;
    assign iter_count  = iter_reg;

endmodule

/* hdl/escape_time_fractal_pixel.sv */
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel
// Escape-time Mandelbrot / Julia evaluation of one pixel in signed fixed point.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake      Item
//  pix      in   valid/ready    pixel_col, pixel_row
//  res      out  valid/ready    color_index, escaped, iter_count
//  cfg      in   cfg_wr_en      cfg_index, cfg_data (write only)
//
//  One pixel is worked on at a time. A pixel runs until its iteration limit L
//  is reached or it escapes, the escape caught by the component bound or by
//  the squared-magnitude compare; a zero limit skips the iterations. Each
//  iteration passes through the three multipliers of the square unit and then
//  the add and escape compare. The result register lets the next pixel be
//  accepted while a result waits; a finished pixel holds until that register
//  is free. Reset loads the default view and clears the control state.
//
module escape_time_fractal_pixel #(
    parameter int COORD_WIDTH = 32,
    parameter int COUNT_WIDTH = 12
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    efp_pix_if.sink                           pix,
    efp_res_if.source                         res,
    input  logic                              cfg_wr_en,
    input  logic [efp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [COORD_WIDTH-1:0]            cfg_data
);

    localparam logic signed [63:0] RS64 = efp_pkg::RST_REAL_START_Q28 <<< 32;
    localparam logic signed [63:0] RD64 = efp_pkg::RST_REAL_STEP_Q28 <<< 32;
    localparam logic signed [63:0] IS64 = efp_pkg::RST_IMAG_START_Q28 <<< 32;
    localparam logic signed [63:0] ID64 = efp_pkg::RST_IMAG_STEP_Q28 <<< 32;
    localparam logic [COORD_WIDTH-1:0] RST_REAL_START = RS64[63 -: COORD_WIDTH];
    localparam logic [COORD_WIDTH-1:0] RST_REAL_STEP  = RD64[63 -: COORD_WIDTH];
    localparam logic [COORD_WIDTH-1:0] RST_IMAG_START = IS64[63 -: COORD_WIDTH];
    localparam logic [COORD_WIDTH-1:0] RST_IMAG_STEP  = ID64[63 -: COORD_WIDTH];

    logic signed [COORD_WIDTH-1:0] real_start_reg;
    logic signed [COORD_WIDTH-1:0] real_step_reg;
    logic signed [COORD_WIDTH-1:0] imag_start_reg;
    logic signed [COORD_WIDTH-1:0] imag_step_reg;
    logic [COUNT_WIDTH-1:0]        iter_limit_reg;
    logic                          julia_enable_reg;
    logic signed [COORD_WIDTH-1:0] julia_c_real_reg;
    logic signed [COORD_WIDTH-1:0] julia_c_imag_reg;

    efp_pkg::efp_cmd_t  cmd;
    efp_pkg::efp_stat_t stat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_start_reg   <= RST_REAL_START;
            real_step_reg    <= RST_REAL_STEP;
            imag_start_reg   <= RST_IMAG_START;
            imag_step_reg    <= RST_IMAG_STEP;
            iter_limit_reg   <= COUNT_WIDTH'(efp_pkg::RST_ITER_LIMIT);
            julia_enable_reg <= 1'b0;
            julia_c_real_reg <= '0;
            julia_c_imag_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                efp_pkg::REG_REAL_START:   real_start_reg   <= cfg_data;
                efp_pkg::REG_REAL_STEP:    real_step_reg    <= cfg_data;
                efp_pkg::REG_IMAG_START:   imag_start_reg   <= cfg_data;
                efp_pkg::REG_IMAG_STEP:    imag_step_reg    <= cfg_data;
                efp_pkg::REG_ITER_LIMIT:   iter_limit_reg   <= cfg_data[COUNT_WIDTH-1:0];
                efp_pkg::REG_JULIA_ENABLE: julia_enable_reg <= cfg_data[0];
                efp_pkg::REG_JULIA_C_REAL: julia_c_real_reg <= cfg_data;
                efp_pkg::REG_JULIA_C_IMAG: julia_c_imag_reg <= cfg_data;
                default:                   julia_enable_reg <= julia_enable_reg;
            endcase
        end
    end

    // Sequencer
    efp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix.valid),
        .in_ready  (pix.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Arithmetic and result register
    efp_dpath #(
        .COORD_WIDTH (COORD_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .pixel_col    (pix.pixel_col),
        .pixel_row    (pix.pixel_row),
        .real_start   (real_start_reg),
        .real_step    (real_step_reg),
        .imag_start   (imag_start_reg),
        .imag_step    (imag_step_reg),
        .iter_limit   (iter_limit_reg),
        .julia_enable (julia_enable_reg),
        .julia_c_real (julia_c_real_reg),
        .julia_c_imag (julia_c_imag_reg),
        .color_index  (res.color_index),
        .escaped      (res.escaped),
        .iter_count   (res.iter_count)
    );

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the escape-time fractal pixel block. Pixels go in
// over the valid/ready input channel, and an in-bench escape-time predictor
// works out the colour, escape flag and iteration count of each accepted
// pixel. Results are checked in order as they leave the block. The run steps
// through several views, iteration limits and both fractal modes, with random
// idling and long stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W = 32;
    localparam int CNT_W   = 12;
    localparam int FRAC_W  = COORD_W - 4;

    typedef struct packed {
        logic [1:0]       color_index;
        logic             escaped;
        logic [CNT_W-1:0] iter_count;
    } pixel_result_t;

    // Predicts each pixel from its own copy of the view registers and checks
    // the block's results against the oldest outstanding prediction.
    class pixel_scoreboard;
        bit [COORD_W-1:0] re_start, re_step, im_start, im_step, c_re, c_im;
        bit [CNT_W-1:0]   limit;
        bit               julia;
        pixel_result_t    due_pixels[$];
        int               n_errors, n_checked, n_escaped, n_inside, deepest;

        function new();
            re_start = COORD_W'(efp_pkg::RST_REAL_START_Q28);
            re_step  = COORD_W'(efp_pkg::RST_REAL_STEP_Q28);
            im_start = COORD_W'(efp_pkg::RST_IMAG_START_Q28);
            im_step  = COORD_W'(efp_pkg::RST_IMAG_STEP_Q28);
            limit    = CNT_W'(efp_pkg::RST_ITER_LIMIT);
            julia    = 1'b0;
            c_re     = '0;
            c_im     = '0;
        endfunction

        function void set_reg(logic [efp_pkg::CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
            case (idx)
                efp_pkg::REG_REAL_START:   re_start = val;
                efp_pkg::REG_REAL_STEP:    re_step  = val;
                efp_pkg::REG_IMAG_START:   im_start = val;
                efp_pkg::REG_IMAG_STEP:    im_step  = val;
                efp_pkg::REG_ITER_LIMIT:   limit    = val[CNT_W-1:0];
                efp_pkg::REG_JULIA_ENABLE: julia    = val[0];
                efp_pkg::REG_JULIA_C_REAL: c_re     = val;
                efp_pkg::REG_JULIA_C_IMAG: c_im     = val;
                default: ;
            endcase
        endfunction

        function pixel_result_t escape_time(logic [efp_pkg::PIX_W-1:0] col,
                                            logic [efp_pkg::PIX_W-1:0] row);
            bit [COORD_W-1:0] pr_w, pi_w;
            longint        zr, zi, cr, ci, nr, ni, sq, prod, bound, bound_sq;
            int unsigned   n, bump, shade;
            bit            out_flag, xo, yo, gap;
            pixel_result_t r;
            // map the pixel onto the plane, wrapping like a plain adder
            pr_w = re_start + COORD_W'(col) * re_step;
            pi_w = im_start + COORD_W'(row) * im_step;
            zr = longint'(signed'(pr_w));
            zi = longint'(signed'(pi_w));
            cr = julia ? longint'(signed'(c_re)) : zr;
            ci = julia ? longint'(signed'(c_im)) : zi;
            bound    = longint'(1) <<< (FRAC_W + 1);
            bound_sq = longint'(1) <<< (2 * FRAC_W + 2);
            n = 0;
            out_flag = 1'b0;
            // iterate z*z + c, arithmetic shifts give floor rounding
            while (n < limit && !out_flag) begin
                sq   = zr * zr - zi * zi;
                prod = zr * zi;
                nr   = (sq >>> FRAC_W) + cr;
                ni   = (prod >>> (FRAC_W - 1)) + ci;
                if (((nr < 0) ? -nr : nr) > bound || ((ni < 0) ? -ni : ni) > bound)
                    out_flag = 1'b1;
                else if (nr * nr + ni * ni > bound_sq)
                    out_flag = 1'b1;
                if (!out_flag) begin
                    zr = nr;
                    zi = ni;
                    n++;
                end
            end
            // dithered colour of the escape iteration
            shade = 0;
            if (out_flag) begin
                xo   = col[0];
                yo   = row[0];
                gap  = yo && !xo;
                case (n % 4)
                    1:       bump = gap;
                    2:       bump = (xo != yo);
                    3:       bump = !gap;
                    default: bump = 0;
                endcase
                shade = (n / 4) % 3 + 1 + bump;
                if (shade > 3)
                    shade = 1;
            end
            r.color_index = shade[1:0];
            r.escaped     = out_flag;
            r.iter_count  = n[CNT_W-1:0];
            return r;
        endfunction

        function void note_pixel(logic [efp_pkg::PIX_W-1:0] col,
                                 logic [efp_pkg::PIX_W-1:0] row);
            due_pixels.push_back(escape_time(col, row));
        endfunction

        function void check_result(logic [1:0] color_index, logic escaped,
                                   logic [CNT_W-1:0] iter_count);
            pixel_result_t want;
            if (due_pixels.size() == 0) begin
                $error("result with no pixel outstanding: colour %0d escaped %0d iters %0d",
                       color_index, escaped, iter_count);
                n_errors++;
                return;
            end
            want = due_pixels.pop_front();
            n_checked++;
            if (color_index !== want.color_index) begin
                $error("color_index: expected %0d, got %0d", want.color_index, color_index);
                n_errors++;
            end
            if (escaped !== want.escaped) begin
                $error("escaped: expected %0d, got %0d", want.escaped, escaped);
                n_errors++;
            end
            if (iter_count !== want.iter_count) begin
                $error("iter_count: expected %0d, got %0d", want.iter_count, iter_count);
                n_errors++;
            end
            if (want.escaped) begin
                n_escaped++;
                if (want.iter_count > deepest)
                    deepest = want.iter_count;
            end
            else
                n_inside++;
        endfunction

        function int pending();
            return due_pixels.size();
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic                          cfg_wr_en;
    logic [efp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]            cfg_data;

    efp_pix_if                         pix_ch();
    efp_res_if #(.COUNT_WIDTH(CNT_W))  res_ch();

    pixel_scoreboard sb;
    bit tx_gaps, rx_gaps;
    int rx_hold_req;
    int n_views;

    escape_time_fractal_pixel #(
        .COORD_WIDTH (COORD_W),
        .COUNT_WIDTH (CNT_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_ch),
        .res       (res_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short idle gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    task automatic write_reg(input logic [efp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [COORD_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic load_view(input logic [COORD_W-1:0] r0, dr, i0, di, lim_word, jul_word,
                             input logic [COORD_W-1:0] jcr, jci);
        write_reg(efp_pkg::REG_REAL_START, r0);
        write_reg(efp_pkg::REG_REAL_STEP, dr);
        write_reg(efp_pkg::REG_IMAG_START, i0);
        write_reg(efp_pkg::REG_IMAG_STEP, di);
        write_reg(efp_pkg::REG_ITER_LIMIT, lim_word);
        write_reg(efp_pkg::REG_JULIA_ENABLE, jul_word);
        write_reg(efp_pkg::REG_JULIA_C_REAL, jcr);
        write_reg(efp_pkg::REG_JULIA_C_IMAG, jci);
        cfg_wr_en <= 1'b0;
        n_views++;
    endtask

    // offer one pixel, keep valid high afterwards for a back-to-back item
    task automatic send_pixel(input logic [efp_pkg::PIX_W-1:0] col,
                              input logic [efp_pkg::PIX_W-1:0] row);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.pixel_col <= col;
        pix_ch.pixel_row <= row;
        do @(posedge clk); while (!pix_ch.ready);
        sb.note_pixel(col, row);
    endtask

    // drop valid and hold until every outstanding pixel has come back
    task automatic pause_until_drained();
        pix_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // result side: check each accepted item, then pick ready for the next cycle
    initial
    begin : result_sink
        int stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.color_index, res_ch.escaped, res_ch.iter_count);
            if (rx_hold_req > 0) begin
                stall_left  = rx_hold_req;
                rx_hold_req = 0;
            end
            else if (stall_left == 0 && rx_gaps && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #40_000_000;
        $display("** escape_time_fractal_pixel: FAILED **");
        $finish;
    end

    // stimulus
    initial
    begin
        int                        ph, k, n_items, sel;
        int unsigned               lim;
        bit                        wild, jul;
        logic [efp_pkg::PIX_W-1:0] col, row;
        logic [COORD_W-1:0]        r0, dr, i0, di, lim_word, jul_word, jcr, jci;

        sb               = new();
        tx_gaps          = 1'b0;
        rx_gaps          = 1'b0;
        rx_hold_req      = 0;
        n_views          = 0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        pix_ch.valid     = 1'b0;
        pix_ch.pixel_col = '0;
        pix_ch.pixel_row = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset view: corners, all pixel parities, points around the set
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd170, 10'd50);
        send_pixel(10'd160, 10'd50);
        send_pixel(10'd171, 10'd51);
        send_pixel(10'd150, 10'd25);
        send_pixel(10'd151, 10'd26);
        send_pixel(10'd140, 10'd45);
        send_pixel(10'd141, 10'd44);
        send_pixel(10'd165, 10'd40);
        pause_until_drained();

        // steps that wrap the coordinate, full iteration limit on the origin
        load_view(32'h0, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'(12'hFFF), 32'h0,
                  32'h7FFF_FFFF, 32'h8000_0000);
        send_pixel(10'd2, 10'd4);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1, 10'd0);
        pause_until_drained();

        // zero iteration limit at the register extremes
        load_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1,
                  32'h8000_0000, 32'h7FFF_FFFF);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1022);
        pause_until_drained();

        // Julia mode with the most negative c escapes at once
        load_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd3, 32'h1,
                  32'h8000_0000, 32'h7FFF_FFFF);
        send_pixel(10'd3, 10'd5);
        send_pixel(10'd1022, 10'd1);
        pause_until_drained();

        // random views, mostly framed around the set
        for (ph = 0; ph < 15; ph++) begin
            wild = (ph == 6 || ph == 13);
            jul  = (ph % 3 == 1) || (wild && $urandom_range(0, 1));
            case (ph)
                4:       lim = 255;
                8:       lim = 4095;
                11:      lim = 1;
                default: lim = wild ? $urandom_range(1, 255) : $urandom_range(2, 48);
            endcase
            if (wild) begin
                r0       = $urandom();
                dr       = $urandom();
                i0       = $urandom();
                di       = $urandom();
                jcr      = $urandom();
                jci      = $urandom();
                lim_word = ($urandom() & 32'hFFFF_F000) | 32'(lim);
                jul_word = {31'($urandom()), jul};
            end
            else begin
                r0 = 32'($urandom_range(0, 3 << 28)) - 32'(5 << 27);
                i0 = 32'($urandom_range(0, 3 << 28)) - 32'(3 << 27);
                dr = $urandom_range(1 << 18, 1 << 20);
                di = $urandom_range(1 << 18, 1 << 20);
                if ($urandom_range(0, 1))
                    dr = -dr;
                if ($urandom_range(0, 1))
                    di = -di;
                jcr      = 32'($urandom_range(0, 3 << 27)) - 32'(1 << 28);
                jci      = 32'($urandom_range(0, 1 << 29)) - 32'(1 << 28);
                lim_word = 32'(lim);
                jul_word = {31'h0, jul};
            end
            load_view(r0, dr, i0, di, lim_word, jul_word, jcr, jci);

            tx_gaps = (ph % 4 != 0);
            rx_gaps = (ph % 4 != 0) && (ph % 4 != 2);
            n_items = (ph == 8) ? 4 : (ph == 4) ? 30 : 125;
            col = $urandom_range(0, 1023);
            row = $urandom_range(0, 1023);
            for (k = 0; k < n_items; k++) begin
                // random pixels mixed with short raster runs
                sel = $urandom_range(0, 3);
                if (sel < 2) begin
                    col = $urandom_range(0, 1023);
                    row = $urandom_range(0, 1023);
                end
                else if (sel == 2)
                    col = col + 1'b1;
                else
                    row = row + 1'b1;
                if (ph == 2 && k == 10)
                    rx_hold_req = 300;
                send_pixel(col, row);
                if (ph == 3 && k == 60)
                    pause_until_drained();
            end
            pause_until_drained();
        end

        // let any stray result show up
        rx_gaps = 1'b0;
        repeat (200) @(posedge clk);
        $display("Checked %0d pixels over %0d views, Mandelbrot and Julia mode.",
                 sb.n_checked, n_views);
        $display("%0d escaped (deepest at iteration %0d), %0d ran to the limit.",
                 sb.n_escaped, sb.deepest, sb.n_inside);
        if (sb.n_errors == 0)
            $display("** escape_time_fractal_pixel: PASSED **");
        else
            $display("** escape_time_fractal_pixel: FAILED **");
        $finish;
    end

endmodule
